@@ design/association_id_allocator_core_defines.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ASSOCIATION_ID_ALLOCATOR_CORE_DEFINES_SVH
`define ASSOCIATION_ID_ALLOCATOR_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define AIA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aia: implication check failed");

// antecedent implies consequent in the next cycle
`define AIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aia: next-cycle check failed");

`endif

@@ design/aia_pkg.sv @@
// Types, constants and codes for the association ID allocator.
package aia_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int MAX_AID       = 2007;

   localparam int MAC_W   = 48;
   localparam int AID_W   = 11;
   localparam int REQ_W   = 3;
   localparam int STAT_W  = 2;

   localparam int SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int AID_MAP_SIZE = 2048;
   localparam int BM_WORD_W    = 32;
   localparam int BM_WORDS     = AID_MAP_SIZE / BM_WORD_W;
   localparam int BIT_AW       = $clog2(BM_WORD_W);
   localparam int WORD_AW      = $clog2(BM_WORDS);
   localparam int LAST_WORD    = MAX_AID / BM_WORD_W;

   localparam logic [REQ_W-1:0] REQ_RESERVE   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_COMMIT    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ALLOCATE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CANCEL    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_ID        = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_RESERVED = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL         = 2'd3;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [MAC_W-1:0] mac_address;
   } aia_req_type;

   typedef struct packed {
      logic [AID_W-1:0]  aid;
      logic [STAT_W-1:0] status;
   } aia_rsp_type;

   typedef struct packed {
      logic [MAC_W-1:0] mac;
      logic [AID_W-1:0] aid;
      logic             committed;
   } aia_slot_type;

   typedef enum logic [1:0] {
      AID_NONE,
      AID_HIT,
      AID_FOUND
   } aia_aid_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_LOOKUP,
      S_SEARCH,
      S_INSTALL,
      S_COMMIT,
      S_DROP_RD,
      S_DROP_WR
   } aia_state_type;

   typedef struct packed {
      logic              accept;
      logic              lookup_start;
      logic              lookup_run;
      logic              search_start;
      logic              search_run;
      logic              install;
      logic              install_committed;
      logic              commit;
      logic              drop_read;
      logic              drop_write;
      logic              clear_all;
      logic              rsp_load;
      aia_aid_sel_type   rsp_aid_sel;
      logic [STAT_W-1:0] rsp_status;
   } aia_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             hit;
      logic             hit_committed;
      logic             lookup_done;
      logic             free_found;
      logic             search_done;
      logic             table_full;
   } aia_stat_type;

endpackage

@@ design/aia_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module aia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/aia_ctrl.sv @@
// Request sequencer: walks lookup, free-ID search and table updates.
module aia_ctrl import aia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  aia_stat_type st,
   output aia_cmd_type  cmd
);

   aia_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (st.req_type) inside
               REQ_RESERVE, REQ_COMMIT, REQ_ALLOCATE, REQ_CANCEL, REQ_RELEASE:
                  state_in = S_LOOKUP;
               default:
                  state_in = S_IDLE;
            endcase
         end
         S_LOOKUP: begin
            if (st.hit) begin
               unique case (st.req_type) inside
                  REQ_COMMIT, REQ_ALLOCATE: state_in = S_COMMIT;
                  REQ_RELEASE:              state_in = S_DROP_RD;
                  REQ_CANCEL:  state_in = st.hit_committed ? S_IDLE : S_DROP_RD;
                  default:                  state_in = S_IDLE;
               endcase
            end else if (st.lookup_done) begin
               unique case (st.req_type) inside
                  REQ_RESERVE, REQ_ALLOCATE: state_in = S_SEARCH;
                  default:                   state_in = S_IDLE;
               endcase
            end
         end
         S_SEARCH: begin
            if (st.free_found) begin
               state_in = st.table_full ? S_IDLE : S_INSTALL;
            end else if (st.search_done) begin
               state_in = S_IDLE;
            end
         end
         S_INSTALL: state_in = S_IDLE;
         S_COMMIT:  state_in = S_IDLE;
         S_DROP_RD: state_in = S_DROP_WR;
         S_DROP_WR: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_aid_sel = AID_NONE;
      cmd.rsp_status  = ST_OK;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = start;
         end
         S_DISPATCH: begin
            unique case (st.req_type) inside
               REQ_RESERVE, REQ_COMMIT, REQ_ALLOCATE, REQ_CANCEL, REQ_RELEASE:
                  cmd.lookup_start = 1'b1;
               REQ_CLEAR_ALL: begin
                  cmd.clear_all = 1'b1;
                  cmd.rsp_load  = 1'b1;
               end
               default:
                  cmd.rsp_load = 1'b1;
            endcase
         end
         S_LOOKUP: begin
            cmd.lookup_run = 1'b1;
            if (st.hit) begin
               unique case (st.req_type) inside
                  REQ_RESERVE: begin
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_aid_sel = AID_HIT;
                  end
                  REQ_CANCEL: begin
                     cmd.rsp_load = st.hit_committed;
                  end
                  default: begin
                  end
               endcase
            end else if (st.lookup_done) begin
               unique case (st.req_type) inside
                  REQ_RESERVE, REQ_ALLOCATE: begin
                     cmd.search_start = 1'b1;
                  end
                  REQ_COMMIT: begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_NOT_RESERVED;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            cmd.search_run = 1'b1;
            if (st.free_found) begin
               if (st.table_full) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_FULL;
               end
            end else if (st.search_done) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_NO_ID;
            end
         end
         S_INSTALL: begin
            cmd.install           = 1'b1;
            cmd.install_committed = (st.req_type == REQ_ALLOCATE);
            cmd.rsp_load          = 1'b1;
            cmd.rsp_aid_sel       = AID_FOUND;
         end
         S_COMMIT: begin
            cmd.commit      = 1'b1;
            cmd.rsp_load    = 1'b1;
            cmd.rsp_aid_sel = AID_HIT;
         end
         S_DROP_RD: begin
            cmd.drop_read = 1'b1;
         end
         S_DROP_WR: begin
            cmd.drop_write = 1'b1;
            cmd.rsp_load   = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ design/aia_dp.sv @@
// Datapath: station table, used-ID bitmap, scan counters and result register.
`include "association_id_allocator_core_defines.svh"

module aia_dp import aia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  aia_cmd_type  cmd,
   output aia_stat_type st,
   input  aia_req_type  req_data,
   output logic         rsp_valid,
   output aia_rsp_type  rsp_data
);

   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);
   localparam logic [WORD_AW-1:0] LAST_WRD  = WORD_AW'(LAST_WORD);

   aia_req_type            req_ff;
   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [BM_WORDS-1:0]    word_valid_ff, word_valid_in;

   logic [SLOT_W-1:0]      slot_cnt_ff, cmp_idx_ff, hit_idx_ff;
   logic                   pend_ff;
   aia_slot_type           hit_entry_ff;

   logic [WORD_AW-1:0]     word_cnt_ff, wcmp_ff;
   logic                   wpend_ff;
   logic [AID_W-1:0]       found_aid_ff;
   logic [BM_WORD_W-1:0]   found_word_ff;

   logic                   rsp_valid_ff;
   aia_rsp_type            rsp_ff;

   aia_slot_type           slot_rdata, slot_wdata;
   logic                   slot_we;
   logic [SLOT_W-1:0]      slot_waddr;

   logic [BM_WORD_W-1:0]   bm_rdata, bm_wdata;
   logic                   bm_we;
   logic [WORD_AW-1:0]     bm_waddr, bm_raddr;

   logic                   hit;
   logic [SLOT_W-1:0]      free_idx;
   logic [BM_WORD_W-1:0]   forced_used, word_eff, used;
   logic                   free_found;
   logic [BIT_AW-1:0]      free_bit;
   logic [WORD_AW-1:0]     hit_word;
   logic [BIT_AW-1:0]      hit_bit;
   logic [BM_WORD_W-1:0]   drop_word;

   assign hit_word = hit_entry_ff.aid[AID_W-1 -: WORD_AW];
   assign hit_bit  = hit_entry_ff.aid[BIT_AW-1:0];

   aia_ram #(.WIDTH($bits(aia_slot_type)), .DEPTH(TABLE_ENTRIES)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_cnt_ff),
      .rdata (slot_rdata)
   );

   aia_ram #(.WIDTH(BM_WORD_W), .DEPTH(BM_WORDS)) u_bitmap_ram (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   // lookup compare on the slot read back this cycle
   assign hit = pend_ff && slot_valid_ff[cmp_idx_ff] &&
                (slot_rdata.mac == req_ff.mac_address);

   always_comb begin
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   // AID 0 and IDs above the maximum never count as free
   always_comb begin
      logic [AID_W-1:0] aid_val;
      for (int b = 0; b < BM_WORD_W; b++) begin
         aid_val = {wcmp_ff, BIT_AW'(b)};
         forced_used[b] = (aid_val == '0) || (aid_val > AID_W'(MAX_AID));
      end
   end

   assign word_eff = word_valid_ff[wcmp_ff] ? bm_rdata : '0;
   assign used     = word_eff | forced_used;

   always_comb begin
      free_bit = '0;
      for (int b = BM_WORD_W - 1; b >= 0; b--) begin
         if (!used[b]) begin
            free_bit = BIT_AW'(b);
         end
      end
   end

   assign free_found = wpend_ff && !(&used);

   assign drop_word = (word_valid_ff[hit_word] ? bm_rdata : '0) &
                      ~(BM_WORD_W'(1) << hit_bit);

   always_comb begin
      slot_we    = cmd.install || cmd.commit;
      slot_waddr = cmd.install ? free_idx : hit_idx_ff;
      if (cmd.install) begin
         slot_wdata.mac       = req_ff.mac_address;
         slot_wdata.aid       = found_aid_ff;
         slot_wdata.committed = cmd.install_committed;
      end else begin
         slot_wdata.mac       = hit_entry_ff.mac;
         slot_wdata.aid       = hit_entry_ff.aid;
         slot_wdata.committed = 1'b1;
      end
   end

   always_comb begin
      bm_raddr = cmd.drop_read ? hit_word : word_cnt_ff;
      bm_we    = cmd.install || cmd.drop_write;
      if (cmd.install) begin
         bm_waddr = found_aid_ff[AID_W-1 -: WORD_AW];
         bm_wdata = found_word_ff | (BM_WORD_W'(1) << found_aid_ff[BIT_AW-1:0]);
      end else begin
         bm_waddr = hit_word;
         bm_wdata = drop_word;
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      word_valid_in = word_valid_ff;
      if (cmd.clear_all) begin
         slot_valid_in = '0;
         word_valid_in = '0;
      end
      if (cmd.install) begin
         slot_valid_in[free_idx] = 1'b1;
         word_valid_in[found_aid_ff[AID_W-1 -: WORD_AW]] = 1'b1;
      end
      if (cmd.drop_write) begin
         slot_valid_in[hit_idx_ff] = 1'b0;
         word_valid_in[hit_word]   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         word_valid_ff <= '0;
         pend_ff       <= 1'b0;
         wpend_ff      <= 1'b0;
         slot_cnt_ff   <= '0;
         word_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         word_valid_ff <= word_valid_in;
         if (cmd.lookup_start) begin
            slot_cnt_ff <= '0;
            pend_ff     <= 1'b0;
         end else if (cmd.lookup_run) begin
            pend_ff <= 1'b1;
            if (slot_cnt_ff != LAST_SLOT) begin
               slot_cnt_ff <= slot_cnt_ff + 1'b1;
            end
         end
         if (cmd.search_start) begin
            word_cnt_ff <= '0;
            wpend_ff    <= 1'b0;
         end else if (cmd.search_run) begin
            wpend_ff <= 1'b1;
            if (word_cnt_ff != LAST_WRD) begin
               word_cnt_ff <= word_cnt_ff + 1'b1;
            end
         end
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      cmp_idx_ff <= slot_cnt_ff;
      wcmp_ff    <= word_cnt_ff;
      if (cmd.lookup_run && hit) begin
         hit_idx_ff   <= cmp_idx_ff;
         hit_entry_ff <= slot_rdata;
      end
      if (cmd.search_run && free_found) begin
         found_aid_ff  <= {wcmp_ff, free_bit};
         found_word_ff <= word_eff;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_status;
         case (cmd.rsp_aid_sel)
            AID_HIT:   rsp_ff.aid <= (cmd.lookup_run && hit) ? slot_rdata.aid
                                                             : hit_entry_ff.aid;
            AID_FOUND: rsp_ff.aid <= found_aid_ff;
            default:   rsp_ff.aid <= '0;
         endcase
      end
   end

   always_comb begin
      st.req_type      = req_ff.req_type;
      st.hit           = hit;
      st.hit_committed = slot_rdata.committed;
      st.lookup_done   = pend_ff && (cmp_idx_ff == LAST_SLOT);
      st.free_found    = free_found;
      st.search_done   = wpend_ff && (wcmp_ff == LAST_WRD);
      st.table_full    = &slot_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AIA_ASSERT_IMPLY(a_err_zero_aid, clock, reset,
      rsp_valid_ff && (rsp_ff.status != ST_OK), rsp_ff.aid == '0)
   `AIA_ASSERT_IMPLY(a_install_free_slot, clock, reset,
      cmd.install, !slot_valid_ff[free_idx])
   `AIA_ASSERT_IMPLY(a_aid_in_range, clock, reset,
      rsp_valid_ff, rsp_ff.aid <= AID_W'(MAX_AID))
   `AIA_ASSERT_NEXT(a_install_marks_used, clock, reset,
      cmd.install, slot_valid_ff[$past(free_idx)])

endmodule

@@ design/association_id_allocator_core.sv @@
// Top level of the association ID allocator: sequencer plus datapath.
//
//   channel  ports                  handshake
//   -------  ---------------------  ----------------------------------
//   request  start, busy, req_data  transfer when start & !busy
//   result   rsp_valid, rsp_data    one-cycle strobe, always taken
//
// One result per request. Clear all and unused codes answer straight from dispatch.
// Other requests walk the station table one slot a cycle, the whole table on a miss;
// a hit ends the walk, and a commit or a drop (read, then write) may follow it.
// A new reservation then scans the used-ID bitmap one 32-bit word a cycle, up to
// word MAX_AID/32, and installs the first free ID unless the table is full.
// Synchronous reset empties table and bitmap; busy drops in the strobe cycle, no stalls.
module association_id_allocator_core import aia_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  aia_req_type req_data,
   output logic        rsp_valid,
   output aia_rsp_type rsp_data
);

   aia_cmd_type  cmd;
   aia_stat_type st;

   aia_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   aia_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
